[hw/rtl/sfl_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the coefficient table of the stereo low-pass FIR.
// Used by the sequencer top level and by the multiply-accumulate datapath.
package sfl_pkg;

    // Filter geometry and number formats.
    localparam int SAMPLE_WIDTH = 16;
    localparam int TAPS         = 42;
    localparam int STORED_COEFS = 42;
    localparam int COEF_W       = 16;
    localparam int FRAC_BITS    = 15;
    localparam int SLOT_W       = $clog2(TAPS);
    localparam int PROD_W       = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W        = PROD_W + $clog2(TAPS) + 1;

    // Control that the sequencer hands to the datapath each cycle.
    typedef struct packed {
        logic              clear;  // start of a new frame, zero the accumulators
        logic              valid;  // a history word is on the read data
        logic              hit;    // the history entry has been written since reset
        logic [SLOT_W-1:0] tap;    // tap number of that history word
    } mac_ctrl_t;

    // Q1.15 low-pass coefficients, symmetric; taps past the table weigh zero.
    function automatic logic signed [COEF_W-1:0] coef_of(input int k);
        logic signed [COEF_W-1:0] c;
        int m;
        m = (k < (STORED_COEFS / 2)) ? k : (STORED_COEFS - 1 - k);
        if (k >= STORED_COEFS || k < 0) begin
            m = -1;
        end
        case (m)
            0:       c = -16'sd224;
            1:       c = -16'sd145;
            2:       c = -16'sd174;
            3:       c = -16'sd191;
            4:       c = -16'sd190;
            5:       c = -16'sd163;
            6:       c = -16'sd105;
            7:       c = -16'sd11;
            8:       c = 16'sd123;
            9:       c = 16'sd297;
            10:      c = 16'sd511;
            11:      c = 16'sd758;
            12:      c = 16'sd1033;
            13:      c = 16'sd1325;
            14:      c = 16'sd1623;
            15:      c = 16'sd1913;
            16:      c = 16'sd2182;
            17:      c = 16'sd2416;
            18:      c = 16'sd2604;
            19:      c = 16'sd2734;
            20:      c = 16'sd2802;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/sfl_mac.sv]
`timescale 1ns / 1ps
// Two-channel multiply-accumulate datapath with truncation and saturation.
// Depends on sfl_pkg for widths, the control struct and the coefficient table.
module sfl_mac
    import sfl_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mac_ctrl_t                      ctrl,
    input  logic [2*SAMPLE_WIDTH-1:0]      rd_data,
    output logic                           busy,
    output logic signed [SAMPLE_WIDTH-1:0] left_res,
    output logic signed [SAMPLE_WIDTH-1:0] right_res
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic signed [SAMPLE_WIDTH-1:0] left_smp;
    logic signed [SAMPLE_WIDTH-1:0] right_smp;
    logic signed [COEF_W-1:0]       coef;
    logic signed [PROD_W-1:0]       prod_l_reg;
    logic signed [PROD_W-1:0]       prod_r_reg;
    logic                           prod_vld_reg;
    logic signed [ACC_W-1:0]        acc_l_reg;
    logic signed [ACC_W-1:0]        acc_r_reg;

    // Divide by 2^15 toward zero, then clamp to the sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] finish(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] q;
        logic signed [SAMPLE_WIDTH-1:0] r;
        biased = acc + $signed({{(ACC_W - FRAC_BITS){1'b0}}, {FRAC_BITS{acc[ACC_W-1]}}});
        q = biased >>> FRAC_BITS;
        if (q > SAT_HI) begin
            r = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (q < SAT_LO) begin
            r = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else begin
            r = q[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

    // Entries never written since reset read as zero.
    assign left_smp  = ctrl.hit ? $signed(rd_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]) : '0;
    assign right_smp = ctrl.hit ? $signed(rd_data[SAMPLE_WIDTH-1:0]) : '0;
    assign coef      = coef_of(int'(ctrl.tap));

    // Product stage: one multiplier per channel, registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.valid && !ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_l_reg <= left_smp * coef;
        prod_r_reg <= right_smp * coef;
    end

    // Accumulate stage.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
    end

    assign busy      = prod_vld_reg;
    assign left_res  = finish(acc_l_reg);
    assign right_res = finish(acc_r_reg);

endmodule

[hw/rtl/stereo_fir_lowpass.sv]
`timescale 1ns / 1ps
// Top level of the stereo 42-tap low-pass FIR: history memory and tap sequencer.
// Depends on sfl_pkg and instantiates sfl_mac.
//
// A stereo frame beat is taken when in_valid is high and in_stall is low. With
// filtering on, the frame is written into a 42-entry history memory that holds
// both channels in one word, and the taps are then read back one per cycle
// through the memory's single read port and multiplied by the shared Q1.15
// coefficient on both channels at once. The filtered frame is loaded into the
// output register once every tap read has passed the read, multiply and
// accumulate pipeline, and the next frame can be taken after that. With
// filtering off, the input frame appears on the output in the cycle after it
// is accepted and the history is left untouched. A finished frame waits in the
// output register while the next frame is already being filtered; the sum of
// that next frame waits for the output register to free. The history reads as
// zero after reset through a valid bit per entry, so no clearing pass is
// needed. filter_enable resets to 1; the user writes it through cfg_we and
// cfg_data only while the block is idle; the block itself does not enforce
// this.
module stereo_fir_lowpass
    import sfl_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  logic signed [SAMPLE_WIDTH-1:0] right_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] left_out,
    output logic signed [SAMPLE_WIDTH-1:0] right_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TAPS - 1);

    state_t                         state_reg;
    logic                           filter_enable_reg;
    logic [SLOT_W-1:0]              pos_reg;
    logic [SLOT_W-1:0]              rd_slot_reg;
    logic [SLOT_W-1:0]              tap_reg;
    logic [SLOT_W-1:0]              rd_tap_reg;
    logic                           rd_valid_reg;
    logic                           rd_hit_reg;
    logic [2*SAMPLE_WIDTH-1:0]      rd_data_reg;
    logic [2*SAMPLE_WIDTH-1:0]      hist_mem [TAPS];
    logic [TAPS-1:0]                hist_vld_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] left_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_out_reg;
    logic                           out_free;
    logic                           in_beat;
    logic                           hist_we;
    logic                           echo_load;
    logic                           drain_done;
    logic                           out_load;
    logic                           mac_busy;
    logic signed [SAMPLE_WIDTH-1:0] left_res;
    logic signed [SAMPLE_WIDTH-1:0] right_res;
    mac_ctrl_t                      mac_ctrl;

    // Handshake: the output register frees when it is empty or being taken.
    // Only an echoed frame needs the output register at the accept edge.
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE) || (!filter_enable_reg && !out_free);
    assign in_beat    = in_valid && !in_stall;
    assign hist_we    = in_beat && filter_enable_reg;
    assign echo_load  = in_beat && !filter_enable_reg;
    assign drain_done = (state_reg == ST_DRAIN) && !rd_valid_reg && !mac_busy && out_free;
    assign out_load   = echo_load || drain_done;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            filter_enable_reg <= cfg_data;
        end
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[pos_reg] <= {left_in, right_in};
        end
        rd_data_reg <= hist_mem[rd_slot_reg];
    end

    // Per-entry written flags and the read-side tags that travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            rd_hit_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_tap_reg   <= '0;
        end
        else
        begin
            if (hist_we)
            begin
                hist_vld_reg[pos_reg] <= 1'b1;
            end
            rd_hit_reg   <= hist_vld_reg[rd_slot_reg];
            rd_valid_reg <= (state_reg == ST_RUN);
            rd_tap_reg   <= tap_reg;
        end
    end

    // Sequencer: walks the taps from the newest sample back, then drains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            rd_slot_reg   <= '0;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
            left_out_reg  <= '0;
            right_out_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        if (filter_enable_reg)
                        begin
                            state_reg   <= ST_RUN;
                            rd_slot_reg <= pos_reg;
                            tap_reg     <= '0;
                        end
                        else
                        begin
                            left_out_reg  <= left_in;
                            right_out_reg <= right_in;
                        end
                    end
                end
                ST_RUN:
                begin
                    rd_slot_reg <= (rd_slot_reg == '0) ? LAST_SLOT : rd_slot_reg - 1'b1;
                    tap_reg     <= tap_reg + 1'b1;
                    if (tap_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_DRAIN;
                        pos_reg   <= (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_done)
                    begin
                        state_reg     <= ST_IDLE;
                        left_out_reg  <= left_res;
                        right_out_reg <= right_res;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath control for this cycle's read data.
    assign mac_ctrl.clear = hist_we;
    assign mac_ctrl.valid = rd_valid_reg;
    assign mac_ctrl.hit   = rd_hit_reg;
    assign mac_ctrl.tap   = rd_tap_reg;

    sfl_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .rd_data   (rd_data_reg),
        .busy      (mac_busy),
        .left_res  (left_res),
        .right_res (right_res)
    );

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

[hw/rtl/sfl_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the stereo low-pass FIR, bound to the top level.
// Depends on sfl_pkg for the sample width.
module sfl_checker
    import sfl_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_we,
    input logic                           cfg_data,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic signed [SAMPLE_WIDTH-1:0] left_in,
    input logic signed [SAMPLE_WIDTH-1:0] right_in,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] left_out,
    input logic signed [SAMPLE_WIDTH-1:0] right_out
);

    logic       en_reg;
    logic [1:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    // Shadow of the enable register and count of frames inside the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg      <= 1'b1;
            pending_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                en_reg <= cfg_data;
            end
            pending_reg <= pending_reg + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its samples.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_out) && $stable(right_out))
        else $error("result samples changed while stalled");

    // No result beat without a frame taken, and at most two frames held.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != 2'd3) && (!out_valid || pending_reg != 2'd0))
        else $error("result beat count does not match frames taken");

    // With filtering off the frame is echoed on the next cycle.
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && !en_reg |=> out_valid && left_out == $past(left_in)
            && right_out == $past(right_in))
        else $error("echoed frame does not match input");

    // With filtering on, the block is busy with the taps after a frame beat.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && en_reg |=> in_stall)
        else $error("frame taken while the taps are being summed");

endmodule

bind stereo_fir_lowpass sfl_checker u_sfl_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for the stereo 42-tap low-pass FIR: stimulus, idling and a scoreboard.
// Depends on sfl_pkg for the sample width, tap count and fraction bits,
// and on stereo_fir_lowpass.
module tb;
    import sfl_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct {
        sample_t left_smp;
        sample_t right_smp;
    } stereo_frame_t;

    // Kinds of sample runs in the random part.
    typedef enum int {
        SRC_NOISE,
        SRC_RAIL,
        SRC_CORNER,
        SRC_QUIET,
        SRC_IMPULSE
    } source_t;

    localparam int      RANDOM_FRAMES = 600;
    localparam int      CHUNK_FRAMES  = 50;
    localparam int      HOLD_CYCLES   = 300;
    localparam sample_t CORNERS [5]   = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF};

    // Predicts each filtered or echoed frame and checks the output beats in order.
    class stereo_fir_board;
        bit            enable;
        sample_t       left_hist [TAPS];
        sample_t       right_hist [TAPS];
        int unsigned   wr_pos;
        int            coef_q15 [TAPS];
        stereo_frame_t expected_frames [$];
        int            faults;

        function new();
            enable = 1'b1;
            wr_pos = 0;
            faults = 0;
            foreach (left_hist[k])
            begin
                left_hist[k]  = '0;
                right_hist[k] = '0;
            end
            coef_q15 = '{-224, -145, -174, -191, -190, -163, -105, -11, 123, 297, 511,
                         758, 1033, 1325, 1623, 1913, 2182, 2416, 2604, 2734, 2802,
                         2802, 2734, 2604, 2416, 2182, 1913, 1623, 1325, 1033, 758,
                         511, 297, 123, -11, -105, -163, -190, -191, -174, -145, -224};
        endfunction

        // Drop the Q1.15 fraction toward zero and clamp to the sample range.
        function sample_t clamp_sum(longint acc);
            longint hi;
            longint q;
            hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
            q  = acc / (longint'(1) << FRAC_BITS);
            if (q > hi)
                return sample_t'(hi);
            if (q < -hi - 1)
                return sample_t'(-hi - 1);
            return sample_t'(q);
        endfunction

        // Input beat: update the delay lines if enabled and queue the expected frame.
        function void note_frame(sample_t l, sample_t r);
            stereo_frame_t f;
            longint        acc_l;
            longint        acc_r;
            int unsigned   slot;
            int            k;
            if (!enable)
            begin
                f.left_smp  = l;
                f.right_smp = r;
            end
            else
            begin
                left_hist[wr_pos]  = l;
                right_hist[wr_pos] = r;
                acc_l = 0;
                acc_r = 0;
                for (k = 0; k < TAPS; k++)
                begin
                    slot  = (wr_pos + TAPS - k) % TAPS;
                    acc_l += longint'(coef_q15[k]) * longint'(left_hist[slot]);
                    acc_r += longint'(coef_q15[k]) * longint'(right_hist[slot]);
                end
                wr_pos      = (wr_pos + 1) % TAPS;
                f.left_smp  = clamp_sum(acc_l);
                f.right_smp = clamp_sum(acc_r);
            end
            expected_frames.push_back(f);
        endfunction

        // An output beat was accepted: compare it with the oldest expected frame.
        function void check_frame(sample_t l, sample_t r);
            stereo_frame_t want;
            if (expected_frames.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("tb: unexpected output beat at %0t: left %0d right %0d",
                             $time, l, r);
                return;
            end
            want = expected_frames.pop_front();
            if (want.left_smp !== l || want.right_smp !== r)
            begin
                faults++;
                if (faults <= 10)
                    $display("tb: mismatch at %0t: left exp %0d got %0d, right exp %0d got %0d",
                             $time, want.left_smp, l, want.right_smp, r);
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cfg_we;
    logic    cfg_data;
    logic    in_valid;
    logic    in_stall;
    sample_t left_in;
    sample_t right_in;
    logic    out_valid;
    logic    out_stall;
    sample_t left_out;
    sample_t right_out;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    stereo_fir_board board = new();

    stereo_fir_lowpass dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Output side: random stalls, one long hold-off on request, none while calm.
    initial
    begin : receiver
        int hold_left;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (hold_left = HOLD_CYCLES; hold_left > 1; hold_left--)
                    @(posedge clk);
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < 33);
            end
        end
    end

    // Check every output beat taken at a clock edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_frame(left_out, right_out);
    end

    // Offer one stereo frame, after an optional idle gap, and hold it until accepted.
    task automatic send_frame(input sample_t l, input sample_t r);
        if (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            left_in  <= sample_t'($urandom);
            right_in <= sample_t'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        do
            @(posedge clk);
        while (in_stall);
        board.note_frame(l, r);
    endtask

    // Stop offering and wait until every expected frame has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write filter_enable; only called while the block is idle.
    task automatic set_enable(input bit en);
        cfg_we   <= 1'b1;
        cfg_data <= en;
        @(posedge clk);
        board.enable = en;
        cfg_we <= 1'b0;
    endtask

    // Send a run of frames of one kind.
    task automatic send_run(input source_t kind, input int len);
        sample_t rail_l;
        sample_t rail_r;
        sample_t l;
        sample_t r;
        int      i;
        rail_l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        rail_r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        for (i = 0; i < len; i++)
        begin
            case (kind)
                SRC_RAIL:
                begin
                    l = rail_l;
                    r = rail_r;
                end
                SRC_CORNER:
                begin
                    l = CORNERS[$urandom_range(0, 4)];
                    r = CORNERS[$urandom_range(0, 4)];
                end
                SRC_QUIET:
                begin
                    l = sample_t'($urandom_range(0, 64)) - 16'sd32;
                    r = sample_t'($urandom_range(0, 64)) - 16'sd32;
                end
                SRC_IMPULSE:
                begin
                    l = (i == 0) ? rail_l : 16'sd0;
                    r = (i == 0) ? rail_r : 16'sd0;
                end
                default:
                begin
                    l = sample_t'($urandom);
                    r = sample_t'($urandom);
                end
            endcase
            send_frame(l, r);
        end
    endtask

    // Main sequence: reset, directed frames, then random chunks under varying settings.
    initial
    begin : stimulus
        int      sent;
        int      chunk;
        int      in_chunk;
        int      len;
        source_t kind;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= 1'b0;
        in_valid <= 1'b0;
        left_in  <= '0;
        right_in <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Filtering on: impulse at full scale, opposite rails, small values, bit patterns.
        set_enable(1'b1);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sd0, 16'sd0);
        send_frame(16'sd0, 16'sd0);
        send_frame(16'sd0, 16'sd0);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sd1, -16'sd1);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sh5555, 16'shAAAA);
        send_frame(16'shAAAA, 16'sh5555);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(16'sh7FFF, 16'sh7FFF);

        // Filtering off: frames are echoed and the delay lines stay as they are.
        wait_drained();
        set_enable(1'b0);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sd0, 16'sd0);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sh1234, -16'sh1234);

        // Filtering back on: the history resumes where it stopped.
        wait_drained();
        set_enable(1'b1);
        send_frame(16'sd0, 16'sd0);
        send_frame(16'sd100, -16'sd100);

        // Random chunks; one calm chunk, one forced echo chunk, one with a long output hold-off.
        sent  = 0;
        chunk = 0;
        while (sent < RANDOM_FRAMES)
        begin
            wait_drained();
            set_enable((chunk == 5) ? 1'b0 : ($urandom_range(0, 4) != 0));
            calm = (chunk == 2);
            if (chunk == 4)
                hold_req = 1'b1;
            in_chunk = 0;
            while (in_chunk < CHUNK_FRAMES)
            begin
                kind = source_t'($urandom_range(0, 4));
                len  = (kind == SRC_RAIL) ? $urandom_range(30, 60) : $urandom_range(4, 30);
                send_run(kind, len);
                in_chunk += len;
            end
            sent += in_chunk;
            chunk++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (board.faults == 0 && board.expected_frames.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
